@@ design/two_operand_instruction_decoder_macros.svh @@
`ifndef TWO_OPERAND_INSTRUCTION_DECODER_MACROS_SVH
`define TWO_OPERAND_INSTRUCTION_DECODER_MACROS_SVH

// Same-cycle implication, checked outside reset
`define TOD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset
`define TOD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/tod_pkg.sv @@
package tod_pkg;

  typedef enum logic [2:0] {
    MODE_IMM      = 3'd0,
    MODE_PSW      = 3'd1,
    MODE_REGDIR   = 3'd2,
    MODE_MEMDIR   = 3'd3,
    MODE_REGINDIR = 3'd4
  } opmode_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_ILLEGAL = 2'd1,
    ST_IMM_DST = 2'd2
  } status_t;

  localparam logic [3:0] MN_CMP  = 4'd4;
  localparam logic [3:0] MN_TEST = 4'd8;
  localparam logic [3:0] MN_PUSH = 4'd9;
  localparam logic [3:0] MN_CALL = 4'd11;

  localparam logic [1:0] OP_COUNT [16] = '{
    2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2,
    2'd2, 2'd1, 2'd1, 2'd1, 2'd0, 2'd2, 2'd2, 2'd2
  };

  typedef struct packed {
    logic [3:0]  mnemonic;
    logic [1:0]  cond_code;
    logic [1:0]  operand_count;
    opmode_t     dst_mode;
    logic [2:0]  dst_reg;
    logic [15:0] dst_ext;
    opmode_t     src_mode;
    logic [2:0]  src_reg;
    logic [15:0] src_ext;
    status_t     status;
  } tod_result_t;

  typedef struct packed {
    logic        vld;
    logic [15:0] word;
  } tod_word_t;

endpackage

@@ design/two_operand_instruction_decoder.sv @@
// Two-operand instruction decoder.
// Input channel: in_valid / in_stall / in_word carry the instruction stream, one
// 16-bit word per item: an opcode word, then zero or one extension word.
// Result channel: out_valid / out_stall carry one decoded instruction per item:
// mnemonic, condition, operand count, per-operand mode, register and extension
// word, and status (ok, illegal two-extension instruction, or immediate
// destination not allowed).
// An instruction that needs no extension word, or one that is illegal, yields
// its item from the opcode word; otherwise from its extension word.
// Path: the accepted last word of an instruction is held in the input register,
// then decoded into the output register, which drives out_valid.
// Throughput: one word per cycle sustained while out_stall is low; a waiting
// result lets the input register take one more word, then the input stalls.
// Stall: when out_stall holds a pending result, the decoder holds its word and
// in_stall rises once the input register is occupied; nothing is dropped.
// Reset (rst_n low, synchronous): both registers empty, decoder expects an
// opcode word.
module two_operand_instruction_decoder
  import tod_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_mnemonic,
  output logic [1:0]  out_cond_code,
  output logic [1:0]  out_operand_count,
  output logic [2:0]  out_dst_mode,
  output logic [2:0]  out_dst_reg,
  output logic [15:0] out_dst_ext,
  output logic [2:0]  out_src_mode,
  output logic [2:0]  out_src_reg,
  output logic [15:0] out_src_ext,
  output logic [1:0]  out_status
);

  tod_word_t   held;
  logic        adv;
  logic        down_ready;
  logic        res_vld;
  tod_result_t res;
  tod_result_t out_res;

  tod_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_word    (in_word),
    .in_stall   (in_stall),
    .down_ready (down_ready),
    .held       (held),
    .adv        (adv)
  );

  tod_decode u_dec (
    .clk     (clk),
    .rst_n   (rst_n),
    .held    (held),
    .adv     (adv),
    .res_vld (res_vld),
    .res     (res)
  );

  tod_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (held.vld && res_vld),
    .res       (res),
    .ready     (down_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_mnemonic      = out_res.mnemonic;
  assign out_cond_code     = out_res.cond_code;
  assign out_operand_count = out_res.operand_count;
  assign out_dst_mode      = 3'(out_res.dst_mode);
  assign out_dst_reg       = out_res.dst_reg;
  assign out_dst_ext       = out_res.dst_ext;
  assign out_src_mode      = 3'(out_res.src_mode);
  assign out_src_reg       = out_res.src_reg;
  assign out_src_ext       = out_res.src_ext;
  assign out_status        = 2'(out_res.status);

endmodule

@@ design/tod_in_stage.sv @@
module tod_in_stage
  import tod_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic [15:0] in_word,
  output logic        in_stall,
  input  logic        down_ready,
  output tod_word_t   held,
  output logic        adv
);

  logic        vld_r;
  logic [15:0] word_r;

  assign adv      = vld_r && down_ready;
  assign in_stall = vld_r && !down_ready;
  assign held     = '{vld: vld_r, word: word_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (!in_stall) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      word_r <= in_word;
    end
  end

endmodule

@@ design/tod_decode.sv @@
`include "two_operand_instruction_decoder_macros.svh"

module tod_decode
  import tod_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  tod_word_t   held,
  input  logic        adv,
  output logic        res_vld,
  output tod_result_t res
);

  typedef enum logic [1:0] {
    PH_OPC = 2'd0,
    PH_DST = 2'd1,
    PH_SRC = 2'd2
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [15:0] held_op_r, held_op_nxt;

  function automatic opmode_t mode_of(input logic [4:0] code);
    opmode_t m;
    unique case (code[4:3])
      2'd0:    m = (code[2:0] == 3'd7) ? MODE_PSW : MODE_IMM;
      2'd1:    m = MODE_REGDIR;
      2'd2:    m = MODE_MEMDIR;
      default: m = MODE_REGINDIR;
    endcase
    return m;
  endfunction

  function automatic logic needs_ext(input opmode_t m);
    return !(m == MODE_REGDIR || m == MODE_PSW);
  endfunction

  function automatic logic uses_reg(input opmode_t m);
    return (m == MODE_REGDIR || m == MODE_REGINDIR);
  endfunction

  function automatic logic imm_dst_ok(input logic [3:0] mn);
    logic ok;
    unique case (mn) inside
      MN_CMP, MN_TEST, MN_PUSH, MN_CALL: ok = 1'b1;
      default:                           ok = 1'b0;
    endcase
    return ok;
  endfunction

  function automatic tod_result_t build(input logic [15:0] op, input logic illegal,
                                        input logic [15:0] dext, input logic [15:0] sext);
    tod_result_t r;
    logic [1:0]  cnt;
    r               = '0;
    r.mnemonic      = op[13:10];
    r.cond_code     = op[15:14];
    cnt             = OP_COUNT[op[13:10]];
    r.operand_count = cnt;
    r.dst_mode      = MODE_IMM;
    r.src_mode      = MODE_IMM;
    r.status        = ST_OK;
    if (cnt > 2'd0) begin
      r.dst_mode = mode_of(op[9:5]);
      r.dst_reg  = uses_reg(r.dst_mode) ? op[7:5] : 3'd0;
      r.dst_ext  = needs_ext(r.dst_mode) ? dext : 16'd0;
    end
    if (cnt > 2'd1) begin
      r.src_mode = mode_of(op[4:0]);
      r.src_reg  = uses_reg(r.src_mode) ? op[2:0] : 3'd0;
      r.src_ext  = needs_ext(r.src_mode) ? sext : 16'd0;
    end
    if (illegal) begin
      r.status  = ST_ILLEGAL;
      r.dst_ext = 16'd0;
      r.src_ext = 16'd0;
    end else if (cnt > 2'd0 && r.dst_mode == MODE_IMM && !imm_dst_ok(op[13:10])) begin
      r.status = ST_IMM_DST;
    end
    return r;
  endfunction

  logic [1:0] w_cnt;
  logic       w_nd, w_ns;

  always_comb begin
    w_cnt       = OP_COUNT[held.word[13:10]];
    w_nd        = (w_cnt > 2'd0) && needs_ext(mode_of(held.word[9:5]));
    w_ns        = (w_cnt > 2'd1) && needs_ext(mode_of(held.word[4:0]));
    phase_nxt   = PH_OPC;
    held_op_nxt = held_op_r;
    res_vld     = 1'b0;
    res         = build(held.word, 1'b0, 16'd0, 16'd0);
    unique case (phase_r)
      PH_DST: begin
        res_vld = 1'b1;
        res     = build(held_op_r, 1'b0, held.word, 16'd0);
      end
      PH_SRC: begin
        res_vld = 1'b1;
        res     = build(held_op_r, 1'b0, 16'd0, held.word);
      end
      default: begin
        held_op_nxt = held.word;
        if (w_nd && w_ns) begin
          res_vld = 1'b1;
          res     = build(held.word, 1'b1, 16'd0, 16'd0);
        end else if (w_nd) begin
          phase_nxt = PH_DST;
        end else if (w_ns) begin
          phase_nxt = PH_SRC;
        end else begin
          res_vld = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_OPC;
      held_op_r <= 16'd0;
    end else if (adv) begin
      phase_r   <= phase_nxt;
      held_op_r <= held_op_nxt;
    end
  end

  `TOD_ASSERT_SAME(a_illegal_no_ext, res_vld && res.status == ST_ILLEGAL,
    res.dst_ext == 16'd0 && res.src_ext == 16'd0, "illegal item carries extension data")
  `TOD_ASSERT_SAME(a_imm_dst_mode, res_vld && res.status == ST_IMM_DST,
    res.dst_mode == MODE_IMM && res.operand_count != 2'd0, "bad immediate flag without imm dst")
  `TOD_ASSERT_NEXT(a_emit_returns, adv && res_vld, phase_r == PH_OPC,
    "phase not back to opcode after a result")
  `TOD_ASSERT_NEXT(a_ext_wait_hold, !adv && phase_r != PH_OPC,
    $stable(phase_r) && $stable(held_op_r), "decoder state moved without an item")

endmodule

@@ design/tod_out_stage.sv @@
module tod_out_stage
  import tod_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load,
  input  tod_result_t res,
  output logic        ready,
  output logic        out_valid,
  input  logic        out_stall,
  output tod_result_t out_res
);

  logic        vld_r;
  tod_result_t res_r;

  assign ready     = !vld_r || !out_stall;
  assign out_valid = vld_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (ready) begin
      vld_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && load) begin
      res_r <= res;
    end
  end

endmodule

@@ tb/sv/tb_top.sv @@
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import tod_pkg::*;

  localparam logic [3:0] MN_ADD  = 4'd0;
  localparam logic [3:0] MN_SUB  = 4'd1;
  localparam logic [3:0] MN_MUL  = 4'd2;
  localparam logic [3:0] MN_DIV  = 4'd3;
  localparam logic [3:0] MN_AND  = 4'd5;
  localparam logic [3:0] MN_OR   = 4'd6;
  localparam logic [3:0] MN_NOT  = 4'd7;
  localparam logic [3:0] MN_POP  = 4'd10;
  localparam logic [3:0] MN_IRET = 4'd12;
  localparam logic [3:0] MN_MOV  = 4'd13;
  localparam logic [3:0] MN_SHL  = 4'd14;
  localparam logic [3:0] MN_SHR  = 4'd15;

  localparam logic [1:0] KIND_IMM_PSW = 2'd0;
  localparam logic [1:0] KIND_REG     = 2'd1;
  localparam logic [1:0] KIND_MEM     = 2'd2;
  localparam logic [1:0] KIND_IND     = 2'd3;
  localparam logic [2:0] PSW_REG      = 3'd7;

  localparam int RESET_CYCLES = 9;
  localparam int LONG_HOLD    = 80;
  localparam int DRAIN_CYCLES = 8;
  localparam int IDLE_LIMIT   = 2000;
  localparam int SEGMENTS     = 14;
  localparam int SEG_WORDS    = 100;
  localparam int MAX_PRINTS   = 40;

  typedef enum logic [1:0] {AWAIT_OPCODE, AWAIT_DST_EXT, AWAIT_SRC_EXT} decode_phase_t;

  typedef struct packed {
    logic [15:0] word;
    logic        typed;
    tod_result_t res;
  } dir_row_t;

  function automatic logic [4:0] opnd(input logic [1:0] kind, input logic [2:0] rnum);
    return {kind, rnum};
  endfunction

  function automatic logic [15:0] opword(input logic [1:0] cc, input logic [3:0] mn,
                                         input logic [4:0] dcode, input logic [4:0] scode);
    return {cc, mn, dcode, scode};
  endfunction

  localparam logic [4:0]  PSW_CODE  = {KIND_IMM_PSW, PSW_REG};
  localparam tod_result_t NO_RESULT = '0;
  localparam int          NUM_DIRECTED = 27;

  localparam dir_row_t DIRECTED [NUM_DIRECTED] = '{
    '{opword(2'd0, MN_IRET, opnd(KIND_IMM_PSW, 3'd0), opnd(KIND_IMM_PSW, 3'd0)), 1'b1,
      '{MN_IRET, 2'd0, 2'd0, MODE_IMM, 3'd0, 16'h0, MODE_IMM, 3'd0, 16'h0, ST_OK}},
    '{opword(2'd3, MN_ADD, opnd(KIND_IMM_PSW, 3'd0), opnd(KIND_MEM, 3'd6)), 1'b1,
      '{MN_ADD, 2'd3, 2'd2, MODE_IMM, 3'd0, 16'h0, MODE_MEMDIR, 3'd0, 16'h0, ST_ILLEGAL}},
    '{opword(2'd2, MN_MOV, opnd(KIND_IND, 3'd7), opnd(KIND_IND, 3'd5)), 1'b1,
      '{MN_MOV, 2'd2, 2'd2, MODE_REGINDIR, 3'd7, 16'h0, MODE_REGINDIR, 3'd5, 16'h0,
        ST_ILLEGAL}},
    '{opword(2'd1, MN_NOT, opnd(KIND_REG, 3'd7), opnd(KIND_REG, 3'd0)), 1'b1,
      '{MN_NOT, 2'd1, 2'd2, MODE_REGDIR, 3'd7, 16'h0, MODE_REGDIR, 3'd0, 16'h0, ST_OK}},
    '{opword(2'd0, MN_SUB, PSW_CODE, PSW_CODE), 1'b1,
      '{MN_SUB, 2'd0, 2'd2, MODE_PSW, 3'd0, 16'h0, MODE_PSW, 3'd0, 16'h0, ST_OK}},
    '{opword(2'd0, MN_ADD, opnd(KIND_IMM_PSW, 3'd3), opnd(KIND_REG, 3'd1)), 1'b0, NO_RESULT},
    '{16'hFFFF, 1'b1,
      '{MN_ADD, 2'd0, 2'd2, MODE_IMM, 3'd0, 16'hFFFF, MODE_REGDIR, 3'd1, 16'h0, ST_IMM_DST}},
    '{opword(2'd1, MN_CMP, opnd(KIND_IMM_PSW, 3'd0), PSW_CODE), 1'b0, NO_RESULT},
    '{16'h0000, 1'b0, NO_RESULT},
    '{opword(2'd2, MN_TEST, opnd(KIND_IMM_PSW, 3'd6), opnd(KIND_REG, 3'd4)), 1'b0, NO_RESULT},
    '{16'hA5A5, 1'b0, NO_RESULT},
    '{opword(2'd3, MN_PUSH, opnd(KIND_IMM_PSW, 3'd1), opnd(KIND_MEM, 3'd2)), 1'b0, NO_RESULT},
    '{16'h5A5A, 1'b0, NO_RESULT},
    '{opword(2'd0, MN_CALL, opnd(KIND_MEM, 3'd5), opnd(KIND_IND, 3'd3)), 1'b0, NO_RESULT},
    '{16'h8000, 1'b0, NO_RESULT},
    '{opword(2'd1, MN_POP, opnd(KIND_IMM_PSW, 3'd2), opnd(KIND_REG, 3'd0)), 1'b0, NO_RESULT},
    '{16'h0001, 1'b0, NO_RESULT},
    '{opword(2'd3, MN_IRET, opnd(KIND_MEM, 3'd7), opnd(KIND_IMM_PSW, 3'd0)), 1'b1,
      '{MN_IRET, 2'd3, 2'd0, MODE_IMM, 3'd0, 16'h0, MODE_IMM, 3'd0, 16'h0, ST_OK}},
    '{opword(2'd2, MN_MUL, opnd(KIND_REG, 3'd2), opnd(KIND_IMM_PSW, 3'd0)), 1'b0, NO_RESULT},
    '{16'hFFFF, 1'b0, NO_RESULT},
    '{opword(2'd2, MN_AND, opnd(KIND_IMM_PSW, 3'd0), opnd(KIND_IMM_PSW, 3'd5)), 1'b1,
      '{MN_AND, 2'd2, 2'd2, MODE_IMM, 3'd0, 16'h0, MODE_IMM, 3'd0, 16'h0, ST_ILLEGAL}},
    '{16'hFFFF, 1'b1,
      '{MN_SHR, 2'd3, 2'd2, MODE_REGINDIR, 3'd7, 16'h0, MODE_REGINDIR, 3'd7, 16'h0,
        ST_ILLEGAL}},
    '{16'h0000, 1'b1,
      '{MN_ADD, 2'd0, 2'd2, MODE_IMM, 3'd0, 16'h0, MODE_IMM, 3'd0, 16'h0, ST_ILLEGAL}},
    '{opword(2'd3, MN_DIV, opnd(KIND_REG, 3'd5), PSW_CODE), 1'b1,
      '{MN_DIV, 2'd3, 2'd2, MODE_REGDIR, 3'd5, 16'h0, MODE_PSW, 3'd0, 16'h0, ST_OK}},
    '{opword(2'd0, MN_OR, PSW_CODE, opnd(KIND_REG, 3'd6)), 1'b0, NO_RESULT},
    '{opword(2'd1, MN_SHL, opnd(KIND_REG, 3'd1), opnd(KIND_IND, 3'd2)), 1'b0, NO_RESULT},
    '{16'h00FF, 1'b0, NO_RESULT}
  };

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [15:0] in_word;
  logic        out_valid;
  logic        out_stall;
  logic [3:0]  out_mnemonic;
  logic [1:0]  out_cond_code;
  logic [1:0]  out_operand_count;
  logic [2:0]  out_dst_mode;
  logic [2:0]  out_dst_reg;
  logic [15:0] out_dst_ext;
  logic [2:0]  out_src_mode;
  logic [2:0]  out_src_reg;
  logic [15:0] out_src_ext;
  logic [1:0]  out_status;

  decode_phase_t dec_phase = AWAIT_OPCODE;
  logic [15:0]   dec_opcode = '0;
  tod_result_t   pending_decodes [$];

  bit no_gaps = 1'b0;
  bit hold_request = 1'b0;
  int words_sent = 0;
  int decodes_checked = 0;
  int illegal_seen = 0;
  int imm_dst_seen = 0;
  int mismatches = 0;

  two_operand_instruction_decoder i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_word           (in_word),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_mnemonic      (out_mnemonic),
    .out_cond_code     (out_cond_code),
    .out_operand_count (out_operand_count),
    .out_dst_mode      (out_dst_mode),
    .out_dst_reg       (out_dst_reg),
    .out_dst_ext       (out_dst_ext),
    .out_src_mode      (out_src_mode),
    .out_src_reg       (out_src_reg),
    .out_src_ext       (out_src_ext),
    .out_status        (out_status)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic opmode_t operand_mode(input logic [4:0] code);
    case (code[4:3])
      KIND_IMM_PSW: return (code[2:0] == PSW_REG) ? MODE_PSW : MODE_IMM;
      KIND_REG:     return MODE_REGDIR;
      KIND_MEM:     return MODE_MEMDIR;
      default:      return MODE_REGINDIR;
    endcase
  endfunction

  function automatic bit takes_ext(input opmode_t m);
    return !(m == MODE_REGDIR || m == MODE_PSW);
  endfunction

  function automatic bit has_reg(input opmode_t m);
    return m == MODE_REGDIR || m == MODE_REGINDIR;
  endfunction

  // Advance the decode state by one word; return 1 when an instruction completes.
  function automatic bit decode_word(input logic [15:0] w, output tod_result_t r);
    logic [15:0] op;
    logic [15:0] dx;
    logic [15:0] sx;
    logic [1:0]  cnt;
    opmode_t     dm;
    opmode_t     sm;
    bit          illegal;
    bit          done;
    op = (dec_phase == AWAIT_OPCODE) ? w : dec_opcode;
    dx = (dec_phase == AWAIT_DST_EXT) ? w : 16'h0;
    sx = (dec_phase == AWAIT_SRC_EXT) ? w : 16'h0;
    cnt = OP_COUNT[op[13:10]];
    dm = operand_mode(op[9:5]);
    sm = operand_mode(op[4:0]);
    illegal = 1'b0;
    done = 1'b1;
    if (dec_phase == AWAIT_OPCODE) begin
      dec_opcode = w;
      illegal = cnt > 0 && takes_ext(dm) && cnt > 1 && takes_ext(sm);
      if (!illegal && cnt > 0 && takes_ext(dm)) begin
        dec_phase = AWAIT_DST_EXT;
        done = 1'b0;
      end else if (!illegal && cnt > 1 && takes_ext(sm)) begin
        dec_phase = AWAIT_SRC_EXT;
        done = 1'b0;
      end
    end else begin
      dec_phase = AWAIT_OPCODE;
    end
    r = '0;
    r.mnemonic = op[13:10];
    r.cond_code = op[15:14];
    r.operand_count = cnt;
    r.dst_mode = MODE_IMM;
    r.src_mode = MODE_IMM;
    r.status = ST_OK;
    if (cnt > 0) begin
      r.dst_mode = dm;
      r.dst_reg = has_reg(dm) ? op[7:5] : 3'd0;
      r.dst_ext = takes_ext(dm) ? dx : 16'h0;
    end
    if (cnt > 1) begin
      r.src_mode = sm;
      r.src_reg = has_reg(sm) ? op[2:0] : 3'd0;
      r.src_ext = takes_ext(sm) ? sx : 16'h0;
    end
    if (illegal) begin
      r.status = ST_ILLEGAL;
      r.dst_ext = 16'h0;
      r.src_ext = 16'h0;
    end else if (cnt > 0 && dm == MODE_IMM && op[13:10] != MN_CMP && op[13:10] != MN_TEST &&
                 op[13:10] != MN_PUSH && op[13:10] != MN_CALL) begin
      r.status = ST_IMM_DST;
    end
    return done;
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    mismatches++;
    if (mismatches <= MAX_PRINTS)
      $display("[%0t] MISMATCH %s: got %h, expected %h", $realtime, what, got, want);
  endtask

  task automatic check_field(input string what, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  always @(posedge clk) begin : result_monitor
    tod_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_decodes.size() == 0) begin
        report_mismatch("unexpected decode", 16'(out_mnemonic), 16'h0);
      end else begin
        want = pending_decodes.pop_front();
        decodes_checked++;
        if (want.status == ST_ILLEGAL) illegal_seen++;
        if (want.status == ST_IMM_DST) imm_dst_seen++;
        check_field("mnemonic", 16'(out_mnemonic), 16'(want.mnemonic));
        check_field("cond_code", 16'(out_cond_code), 16'(want.cond_code));
        check_field("operand_count", 16'(out_operand_count), 16'(want.operand_count));
        check_field("dst_mode", 16'(out_dst_mode), 16'(want.dst_mode));
        check_field("dst_reg", 16'(out_dst_reg), 16'(want.dst_reg));
        check_field("dst_ext", out_dst_ext, want.dst_ext);
        check_field("src_mode", 16'(out_src_mode), 16'(want.src_mode));
        check_field("src_reg", 16'(out_src_reg), 16'(want.src_reg));
        check_field("src_ext", out_src_ext, want.src_ext);
        check_field("status", 16'(out_status), 16'(want.status));
      end
    end
  end

  initial begin : output_stall_driver
    int stall_left;
    int free_left;
    int r;
    stall_left = 0;
    free_left = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        stall_left = LONG_HOLD;
      end else if (stall_left == 0 && free_left == 0) begin
        r = $urandom_range(0, 99);
        stall_left = (r < 50) ? 0 : (r < 85) ? $urandom_range(1, 3) :
                     (r < 97) ? $urandom_range(4, 12) : $urandom_range(20, 40);
        free_left = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 80) :
                    $urandom_range(0, 5);
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        if (free_left > 0) free_left--;
      end
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle = 0;
      else idle++;
    end
    $display("Some tests failed");
    $finish;
  end

  function automatic int sender_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(15, 30);
  endfunction

  task automatic send_word(input logic [15:0] w, input logic typed, input tod_result_t typed_res);
    int gap;
    tod_result_t r;
    gap = sender_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (in_stall);
    words_sent++;
    if (decode_word(w, r)) pending_decodes.push_back(typed ? typed_res : r);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_decodes.size() != 0);
  endtask

  function automatic logic [4:0] random_operand();
    logic [4:0] code;
    code = 5'($urandom);
    return ($urandom_range(0, 7) == 0) ? PSW_CODE : code;
  endfunction

  function automatic logic [15:0] random_ext();
    logic [15:0] w;
    int r;
    w = 16'($urandom);
    r = $urandom_range(0, 9);
    return (r == 0) ? 16'h0000 : (r == 1) ? 16'hFFFF : w;
  endfunction

  task automatic send_random_instruction();
    logic [15:0] w;
    logic [1:0]  cc;
    logic [3:0]  mn;
    w = 16'($urandom);
    cc = 2'($urandom);
    mn = 4'($urandom);
    // drop in a raw word now and then to break instruction framing
    if ($urandom_range(0, 9) == 0) begin
      send_word(w, 1'b0, NO_RESULT);
    end else begin
      send_word(opword(cc, mn, random_operand(), random_operand()), 1'b0, NO_RESULT);
      if (dec_phase != AWAIT_OPCODE) send_word(random_ext(), 1'b0, NO_RESULT);
    end
  endtask

  initial begin : stimulus
    int seg;
    int seg_end;
    tod_result_t left;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_word = 16'h0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    foreach (DIRECTED[i]) send_word(DIRECTED[i].word, DIRECTED[i].typed, DIRECTED[i].res);
    wait_drained();
    for (seg = 0; seg < SEGMENTS; seg++) begin
      no_gaps = (seg % 4 == 1);
      if (seg == 3 || seg == 10) hold_request = 1'b1;
      seg_end = words_sent + SEG_WORDS;
      while (words_sent < seg_end) send_random_instruction();
      if (seg % 5 == 2) wait_drained();
    end
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    while (pending_decodes.size() != 0) begin
      left = pending_decodes.pop_front();
      report_mismatch("missing decode", 16'h0, 16'(left.mnemonic));
    end
    $display("Fed %0d stream words; checked %0d decodes (%0d illegal, %0d bad imm destination).",
             words_sent, decodes_checked, illegal_seen, imm_dst_seen);
    $display("Ran bursts, random stalls, long output hold-offs and drained pauses; %0d mismatches.",
             mismatches);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+design
design/tod_pkg.sv
design/tod_in_stage.sv
design/tod_decode.sv
design/tod_out_stage.sv
design/two_operand_instruction_decoder.sv
tb/sv/tb_top.sv
